FILE: src/bpp_pkg.sv
package bpp_pkg;

   // field widths
   localparam int COORD_W   = 32;
   localparam int LEN_W     = 31;
   localparam int NUM_AXES  = 3;
   localparam int CSR_IDX_W = 2;

   // default number of active axes
   localparam int DIMENSIONS_DEFAULT = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_HALF_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HALF_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HALF_Z = 2'd2;

   // per-axis results handed from an axis slice to the core
   typedef struct packed {
      logic                      is_in;
      logic                      sph_in;
      logic                      clamp;
      logic signed [COORD_W:0]   gap;
      logic [COORD_W-1:0]        face;
   } axis_type;

   // one result item
   typedef struct packed {
      logic                                is_inside;
      logic                                sphere_inside;
      logic [NUM_AXES-1:0][COORD_W-1:0]    proj;
      logic [NUM_AXES-1:0]                 mask;
   } result_type;

endpackage

FILE: src/bpp_axis.sv
module bpp_axis (
   input  logic [bpp_pkg::COORD_W-1:0] coord,
   input  logic [bpp_pkg::LEN_W-1:0]   radius,
   input  logic [bpp_pkg::LEN_W-1:0]   half_len,
   output bpp_pkg::axis_type           axis_out
);
   import bpp_pkg::*;

   logic [COORD_W-1:0] mag;
   logic [LEN_W:0]     shrink_diff;
   logic [LEN_W-1:0]   shrunk;
   logic [COORD_W-1:0] shrunk_ext;
   logic [COORD_W:0]   mag_plus_rad;

   // magnitude of the coordinate, zero counts as positive
   assign mag = coord[COORD_W-1] ? (~coord + {{(COORD_W-1){1'b0}}, 1'b1}) : coord;

   // half-length shrunk by the radius, floored at zero
   assign shrink_diff = {1'b0, half_len} - {1'b0, radius};
   assign shrunk      = shrink_diff[LEN_W] ? '0 : shrink_diff[LEN_W-1:0];
   assign shrunk_ext  = {1'b0, shrunk};

   assign mag_plus_rad = {1'b0, mag} + {2'b00, radius};

   // tests, clamp decision, face distance and signed face position
   always_comb begin
      axis_out.is_in  = (mag <= {1'b0, half_len});
      axis_out.sph_in = (mag_plus_rad <= {2'b00, half_len});
      axis_out.clamp  = (mag > shrunk_ext);
      axis_out.gap    = $signed({1'b0, shrunk_ext}) - $signed({1'b0, mag});
      axis_out.face   = coord[COORD_W-1] ? (~shrunk_ext + {{(COORD_W-1){1'b0}}, 1'b1})
                                         : shrunk_ext;
   end

endmodule

FILE: src/bpp_core.sv
module bpp_core #(
   parameter int DIMENSIONS = bpp_pkg::DIMENSIONS_DEFAULT
) (
   input  logic [bpp_pkg::NUM_AXES-1:0][bpp_pkg::COORD_W-1:0] coord,
   input  logic [bpp_pkg::LEN_W-1:0]                          radius,
   input  logic [bpp_pkg::NUM_AXES-1:0][bpp_pkg::LEN_W-1:0]   half_len,
   output bpp_pkg::result_type                                result
);
   import bpp_pkg::*;

   // out-of-range dimension counts go to the nearest legal value
   localparam int DIMS = (DIMENSIONS < 1) ? 1 : ((DIMENSIONS > NUM_AXES) ? NUM_AXES : DIMENSIONS);

   axis_type            axis [NUM_AXES];
   logic [NUM_AXES-1:0] clamp;
   logic [NUM_AXES-1:0] pick;
   logic [NUM_AXES-1:0] hit;
   logic                any_clamp;
   logic signed [COORD_W:0] dist_x;
   logic signed [COORD_W:0] dist_y;
   logic signed [COORD_W:0] dist_z;

   // one slice per active axis, inactive axes pass every test
   for (genvar k = 0; k < NUM_AXES; k++) begin : g_axis
      if (k < DIMS) begin : g_active
         bpp_axis u_axis (
            .coord    (coord[k]),
            .radius   (radius),
            .half_len (half_len[k]),
            .axis_out (axis[k])
         );
      end else begin : g_idle
         assign axis[k] = '{is_in: 1'b1, sph_in: 1'b1, clamp: 1'b0, gap: '0, face: '0};
      end
      assign clamp[k] = axis[k].clamp;
   end

   assign any_clamp = |clamp;
   assign dist_x    = axis[0].gap;
   assign dist_y    = axis[1].gap;
   assign dist_z    = axis[2].gap;

   // nearest face; on a tie x loses to y or z, and y wins over z
   always_comb begin
      pick = '0;
      if (DIMS == 1) begin
         pick[0] = 1'b1;
      end else if (DIMS == 2) begin
         if (dist_x < dist_y) pick[0] = 1'b1;
         else                 pick[1] = 1'b1;
      end else if (dist_z < dist_y) begin
         if (dist_x < dist_z) pick[0] = 1'b1;
         else                 pick[2] = 1'b1;
      end else begin
         if (dist_x < dist_y) pick[0] = 1'b1;
         else                 pick[1] = 1'b1;
      end
   end

   // projection and mask
   always_comb begin
      result.is_inside     = axis[0].is_in & axis[1].is_in & axis[2].is_in;
      result.sphere_inside = axis[0].sph_in & axis[1].sph_in & axis[2].sph_in;
      for (int k = 0; k < NUM_AXES; k++) begin
         hit[k] = (k < DIMS) && (clamp[k] || (!any_clamp && pick[k]));
         result.mask[k] = hit[k];
         if (k >= DIMS)   result.proj[k] = '0;
         else if (hit[k]) result.proj[k] = axis[k].face;
         else             result.proj[k] = coord[k];
      end
   end

endmodule

FILE: src/box_point_project_and_test_top.sv
// Box point test and projection. Each item is a point (signed Q16.16 per axis) and a
// radius; the result tells whether the point lies in the origin-centred box, whether the
// sphere of that radius fits wholly inside, and gives the point projected onto the box
// surface shrunk by the radius, with a mask of the clamped or face-snapped axes. One
// result per item, delivered in order. An item passes an input register and a result
// register, and its result shows on the rsp port from the result register. One item is
// taken every cycle unless rsp_stall holds the pipeline; the rate is set by the single
// pass of compares and subtracts between the two registers. When both registers are full,
// rsp_stall reaches req_stall in the same cycle. The user must see that the half-lengths
// are written through the csr port while no item is in flight; the block does not check.
module box_point_project_and_test_top #(
   parameter int DIMENSIONS = bpp_pkg::DIMENSIONS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_write,
   input  logic [bpp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bpp_pkg::LEN_W-1:0]         csr_data,
   // input items
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [bpp_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [bpp_pkg::COORD_W-1:0] req_coord_y,
   input  logic signed [bpp_pkg::COORD_W-1:0] req_coord_z,
   input  logic [bpp_pkg::LEN_W-1:0]         req_radius,
   // result items
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_is_inside,
   output logic                              rsp_sphere_inside,
   output logic signed [bpp_pkg::COORD_W-1:0] rsp_proj_x,
   output logic signed [bpp_pkg::COORD_W-1:0] rsp_proj_y,
   output logic signed [bpp_pkg::COORD_W-1:0] rsp_proj_z,
   output logic [bpp_pkg::NUM_AXES-1:0]      rsp_clamp_mask
);
   import bpp_pkg::*;

   logic [NUM_AXES-1:0][LEN_W-1:0]   half_len_ff;
   logic [NUM_AXES-1:0][LEN_W-1:0]   half_len_in;
   logic                             in_valid_ff;
   logic                             in_valid_in;
   logic [NUM_AXES-1:0][COORD_W-1:0] coord_ff;
   logic [NUM_AXES-1:0][COORD_W-1:0] coord_in;
   logic [LEN_W-1:0]                 radius_ff;
   logic [LEN_W-1:0]                 radius_in;
   logic                             out_valid_ff;
   logic                             out_valid_in;
   result_type                       result_ff;
   result_type                       result_in;
   result_type                       core_result;
   logic                             out_move;
   logic                             in_load;

   // half-length registers
   always_comb begin
      half_len_in = half_len_ff;
      if (csr_write) begin
         case (csr_index)
            REG_HALF_X: half_len_in[0] = csr_data;
            REG_HALF_Y: half_len_in[1] = csr_data;
            REG_HALF_Z: half_len_in[2] = csr_data;
            default:    half_len_in = half_len_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) half_len_ff <= '0;
      else       half_len_ff <= half_len_in;
   end

   // pipeline flow control
   assign out_move  = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !out_move;
   assign in_load   = !req_stall;

   assign in_valid_in  = in_load ? req_valid : in_valid_ff;
   assign coord_in     = in_load ? {req_coord_z, req_coord_y, req_coord_x} : coord_ff;
   assign radius_in    = in_load ? req_radius : radius_ff;
   assign out_valid_in = out_move ? in_valid_ff : out_valid_ff;

   // input register
   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else       in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      coord_ff  <= coord_in;
      radius_ff <= radius_in;
   end

   // projection logic
   bpp_core #(
      .DIMENSIONS (DIMENSIONS)
   ) u_core (
      .coord    (coord_ff),
      .radius   (radius_ff),
      .half_len (half_len_ff),
      .result   (core_result)
   );

   assign result_in = out_move ? core_result : result_ff;

   // result register
   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else       out_valid_ff <= out_valid_in;
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_is_inside     = result_ff.is_inside;
   assign rsp_sphere_inside = result_ff.sphere_inside;
   assign rsp_proj_x        = result_ff.proj[0];
   assign rsp_proj_y        = result_ff.proj[1];
   assign rsp_proj_z        = result_ff.proj[2];
   assign rsp_clamp_mask    = result_ff.mask;

endmodule

FILE: src/bpp_checker.sv
module bpp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic                              rsp_is_inside,
   input logic                              rsp_sphere_inside,
   input logic signed [bpp_pkg::COORD_W-1:0] rsp_proj_x,
   input logic [bpp_pkg::NUM_AXES-1:0]      rsp_clamp_mask
);
   import bpp_pkg::*;

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_proj_x)
                                 && $stable(rsp_clamp_mask))
      else $error("stalled result item changed");

   // input side backs up only behind a stalled full result register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req_stall without a stalled result");

   // every result clamps or snaps at least one axis
   a_mask_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_clamp_mask != '0)
      else $error("result with empty clamp mask");

   // a sphere that fits implies the point is inside
   a_sphere_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sphere_inside |-> rsp_is_inside)
      else $error("sphere inside but point outside");

endmodule

bind box_point_project_and_test_top bpp_checker u_bpp_checker (.*);
